// File: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted insertion table.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  localparam int TABLE_DEPTH_DEFAULT  = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 32;
  localparam int COUNT_BITS_DEFAULT   = $clog2(TABLE_DEPTH_DEFAULT + 1);
  localparam int SCORE_BITS           = 7;
  localparam int FUNC_BITS            = 2;
  localparam int STATUS_BITS          = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PUT,
    S_FETCH,
    S_RESP
  } seq_state_t;

endpackage

`default_nettype wire

// File: src/sit_if.sv
// ----------------------------------------------------------------------------
// sit_req_if / sit_rsp_if
// Valid/ready channels for operation requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_req_if #(
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic [sit_pkg::FUNC_BITS-1:0]  func;
  logic [sit_pkg::SCORE_BITS-1:0] new_score;
  logic [PAYLOAD_BITS-1:0]        new_payload;

  modport source (output valid, output func, output new_score, output new_payload,
                  input ready);
  modport sink   (input valid, input func, input new_score, input new_payload,
                  output ready);
endinterface

interface sit_rsp_if #(
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT,
  parameter int COUNT_BITS   = sit_pkg::COUNT_BITS_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic [sit_pkg::SCORE_BITS-1:0]  entry_score;
  logic [PAYLOAD_BITS-1:0]         entry_payload;
  logic [COUNT_BITS-1:0]           entry_count;
  logic [sit_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output entry_score, output entry_payload,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input entry_score, input entry_payload,
                  input entry_count, input status, output ready);
endinterface

`default_nettype wire

// File: src/sit_store.sv
// ----------------------------------------------------------------------------
// sit_store
// Entry memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_store #(
  parameter int TABLE_DEPTH  = sit_pkg::TABLE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT,
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [ADDR_BITS-1:0]           wr_addr,
  input  wire logic [sit_pkg::SCORE_BITS-1:0] wr_score,
  input  wire logic [PAYLOAD_BITS-1:0]        wr_payload,
  input  wire logic                           rd_en,
  input  wire logic [ADDR_BITS-1:0]           rd_addr,
  output logic      [sit_pkg::SCORE_BITS-1:0] rd_score,
  output logic      [PAYLOAD_BITS-1:0]        rd_payload
);
  import sit_pkg::*;

  logic [SCORE_BITS-1:0]   score_mem   [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      score_mem[wr_addr]   <= wr_score;
      payload_mem[wr_addr] <= wr_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_score   <= score_mem[rd_addr];
      rd_payload <= payload_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/sit_seq.sv
// ----------------------------------------------------------------------------
// sit_seq
// Operation sequencer: tail-to-head shift scan for insert, cursor and count
// bookkeeping, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_seq #(
  parameter int TABLE_DEPTH  = sit_pkg::TABLE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT,
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH),
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  sit_req_if.sink                             req,
  sit_rsp_if.source                           rsp,
  output logic                                wr_en,
  output logic      [ADDR_BITS-1:0]           wr_addr,
  output logic      [sit_pkg::SCORE_BITS-1:0] wr_score,
  output logic      [PAYLOAD_BITS-1:0]        wr_payload,
  output logic                                rd_en,
  output logic      [ADDR_BITS-1:0]           rd_addr,
  input  wire logic [sit_pkg::SCORE_BITS-1:0] rd_score,
  input  wire logic [PAYLOAD_BITS-1:0]        rd_payload
);
  import sit_pkg::*;

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(TABLE_DEPTH);

  seq_state_t              state, state_next;
  logic [SCORE_BITS-1:0]   new_score;
  logic [PAYLOAD_BITS-1:0] new_payload;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic [ADDR_BITS-1:0]    cursor, cursor_next;
  logic [ADDR_BITS-1:0]    idx, idx_next;
  logic [ADDR_BITS-1:0]    show_idx, show_idx_next;
  logic                    shown, shown_next;
  logic                    full_flag, full_flag_next;
  logic                    accept;
  logic                    shift_up;
  logic                    load_out;
  logic [ADDR_BITS-1:0]    read_pos;
  logic [COUNT_BITS-1:0]   read_pos_inc;

  logic                    out_valid;
  logic [SCORE_BITS-1:0]   out_score;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [COUNT_BITS-1:0]   out_count;
  status_t                 out_status;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign shift_up     = (rd_score >= new_score);
  assign read_pos     = (COUNT_BITS'(cursor) >= count) ? '0 : cursor;
  assign read_pos_inc = COUNT_BITS'(read_pos) + COUNT_BITS'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(req.func) == OP_INSERT && count != FULL_COUNT) begin
            state_next = (count == '0) ? S_PUT : S_RD;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_RD:    state_next = S_CMP;
      S_CMP: begin
        if (shift_up && idx != '0) begin
          state_next = S_RD;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT:   state_next = S_FETCH;
      S_FETCH: state_next = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next     = count;
    cursor_next    = cursor;
    idx_next       = idx;
    show_idx_next  = show_idx;
    shown_next     = shown;
    full_flag_next = full_flag;
    wr_en          = 1'b0;
    wr_addr        = idx + ADDR_BITS'(1);
    wr_score       = rd_score;
    wr_payload     = rd_payload;
    rd_en          = 1'b0;
    rd_addr        = idx;
    load_out       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          shown_next     = 1'b0;
          full_flag_next = 1'b0;
          unique case (op_t'(req.func))
            OP_INSERT: begin
              if (count == FULL_COUNT) begin
                full_flag_next = 1'b1;
              end else if (count != '0) begin
                idx_next = ADDR_BITS'(count - COUNT_BITS'(1));
              end else begin
                idx_next = '0;
              end
            end
            OP_REMOVE: begin
              if (count != '0) begin
                count_next = count - COUNT_BITS'(1);
              end
            end
            OP_READ: begin
              if (count != '0) begin
                show_idx_next = read_pos;
                shown_next    = 1'b1;
                cursor_next   = (read_pos_inc >= count) ? '0 : ADDR_BITS'(read_pos_inc);
              end
            end
            OP_CLEAR: begin
              count_next  = '0;
              cursor_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      S_CMP: begin
        if (shift_up) begin
          wr_en = 1'b1;
          if (idx != '0) begin
            idx_next = idx - ADDR_BITS'(1);
          end
        end else begin
          idx_next = idx + ADDR_BITS'(1);
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_score   = new_score;
        wr_payload = new_payload;
        count_next = count + COUNT_BITS'(1);
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = shown ? show_idx : ADDR_BITS'(count - COUNT_BITS'(1));
      end
      S_RESP: begin
        load_out = !out_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      shown     <= 1'b0;
      full_flag <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cursor    <= cursor_next;
      shown     <= shown_next;
      full_flag <= full_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    show_idx <= show_idx_next;
    if (accept) begin
      new_score   <= req.new_score;
      new_payload <= req.new_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_score   <= (count == '0) ? '0 : rd_score;
      out_payload <= (count == '0) ? '0 : rd_payload;
      out_count   <= count;
      if (full_flag) begin
        out_status <= ST_FULL;
      end else if (count == '0) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_OK;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.entry_score   = out_score;
  assign rsp.entry_payload = out_payload;
  assign rsp.entry_count   = out_count;
  assign rsp.status        = out_status;

endmodule

`default_nettype wire

// File: src/sorted_insertion_table.sv
// ----------------------------------------------------------------------------
// sorted_insertion_table
// Bounded table of score/payload entries kept in ascending score order.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         func, new_score, new_payload
//  rsp      out        entry_score, entry_payload, entry_count, status
//
// Remove, read next, clear and a refused insert go from accept to the fetch
// read and then the response state. An insert first scans from the tail toward
// the head, reading one entry per compare through the single memory read port
// and moving each entry whose score is not below the new one a place toward the
// tail, then writes the new entry and fetches. One operation is in flight at a
// time. Reset clears the state, count, cursor and flags; the memory needs no
// clearing. A stalled response holds the block before it accepts requests again.
`default_nettype none

module sorted_insertion_table #(
  parameter int TABLE_DEPTH  = sit_pkg::TABLE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  sit_req_if.sink   req,
  sit_rsp_if.source rsp
);
  import sit_pkg::*;

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

  logic                    wr_en;
  logic [ADDR_BITS-1:0]    wr_addr;
  logic [SCORE_BITS-1:0]   wr_score;
  logic [PAYLOAD_BITS-1:0] wr_payload;
  logic                    rd_en;
  logic [ADDR_BITS-1:0]    rd_addr;
  logic [SCORE_BITS-1:0]   rd_score;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  sit_seq #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_score   (wr_score),
    .wr_payload (wr_payload),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_score   (rd_score),
    .rd_payload (rd_payload)
  );

  sit_store #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_score   (wr_score),
    .wr_payload (wr_payload),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_score   (rd_score),
    .rd_payload (rd_payload)
  );

endmodule

`default_nettype wire

// File: src/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks of the sorted insertion table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_checker #(
  parameter int TABLE_DEPTH  = sit_pkg::TABLE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = sit_pkg::PAYLOAD_BITS_DEFAULT,
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1)
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [sit_pkg::SCORE_BITS-1:0]  entry_score,
  input wire logic [PAYLOAD_BITS-1:0]         entry_payload,
  input wire logic [COUNT_BITS-1:0]           entry_count,
  input wire logic [sit_pkg::STATUS_BITS-1:0] status
);
  import sit_pkg::*;

  // Each transaction on the request side is followed by busy cycles.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous operation still running");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_score)
      && $stable(entry_payload) && $stable(entry_count) && $stable(status))
    else $error("stalled response changed");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_EMPTY && entry_count == '0)
      || (status == ST_OK && entry_count != '0)
      || (status == ST_FULL && entry_count == COUNT_BITS'(TABLE_DEPTH)))
    else $error("status disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && entry_count == '0 |-> entry_score == '0 && entry_payload == '0)
    else $error("empty table shows a nonzero entry");

endmodule

bind sorted_insertion_table sit_checker #(
  .TABLE_DEPTH  (TABLE_DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_sit_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .entry_score   (rsp.entry_score),
  .entry_payload (rsp.entry_payload),
  .entry_count   (rsp.entry_count),
  .status        (rsp.status)
);

`default_nettype wire

// File: tb/sv/tb_sorted_insertion_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insertion_table
// Self-checking testbench for the sorted insertion table. Operations are sent
// over the request channel with random gaps, and each is scored against a
// behavioral copy of the table. Each response transaction is compared field by
// field with the oldest prediction. Directed tests cover the empty and full
// table cases and read cursor, then biased random traffic fills and drains it.
// ----------------------------------------------------------------------------

module tb_sorted_insertion_table;
  import sit_pkg::*;

  localparam int DEPTH       = 16;
  localparam int PAY_BITS    = 32;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [PAY_BITS-1:0]   payload;
    logic [4:0]            count;
    status_t               status;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sit_req_if #(.PAYLOAD_BITS(PAY_BITS)) req_ch ();
  sit_rsp_if #(.PAYLOAD_BITS(PAY_BITS)) rsp_ch ();

  sorted_insertion_table #(
    .TABLE_DEPTH (DEPTH),
    .PAYLOAD_BITS(PAY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [SCORE_BITS-1:0] score_tbl [DEPTH];
  logic [PAY_BITS-1:0]   payload_tbl [DEPTH];
  int unsigned           fill_cnt;
  int unsigned           read_ptr;

  table_result_t expected_results [$];
  table_result_t want;
  int            err_count;
  int            cycle_count;
  bit            idle_on;

  always #4 clk = ~clk;

  function automatic table_result_t predict_table_op(op_t op, logic [SCORE_BITS-1:0] score,
                                                     logic [PAY_BITS-1:0] payload);
    table_result_t r;
    bit            shown;
    int unsigned   pos;
    r      = '0;
    r.status = ST_OK;
    shown  = 1'b0;
    case (op)
      OP_INSERT: begin
        if (fill_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill_cnt && score_tbl[pos] < score) pos++;
          for (int i = fill_cnt; i > pos; i--) begin
            score_tbl[i]   = score_tbl[i-1];
            payload_tbl[i] = payload_tbl[i-1];
          end
          score_tbl[pos]   = score;
          payload_tbl[pos] = payload;
          fill_cnt++;
        end
      end
      OP_REMOVE: begin
        if (fill_cnt > 0) fill_cnt--;
      end
      OP_READ: begin
        if (fill_cnt > 0) begin
          if (read_ptr >= fill_cnt) read_ptr = 0;
          r.score   = score_tbl[read_ptr];
          r.payload = payload_tbl[read_ptr];
          shown     = 1'b1;
          read_ptr++;
          if (read_ptr >= fill_cnt) read_ptr = 0;
        end
      end
      default: begin
        fill_cnt = 0;
        read_ptr = 0;
      end
    endcase
    if (!shown && fill_cnt > 0) begin
      r.score   = score_tbl[fill_cnt-1];
      r.payload = payload_tbl[fill_cnt-1];
    end
    if (r.status != ST_FULL && fill_cnt == 0) r.status = ST_EMPTY;
    r.count = fill_cnt[4:0];
    return r;
  endfunction

  task automatic send_op(input op_t op, input logic [SCORE_BITS-1:0] score,
                         input logic [PAY_BITS-1:0] payload);
    @(negedge clk);
    if (idle_on) begin
      while ($urandom_range(99) < 14) begin
        req_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    req_ch.func        = op;
    req_ch.new_score   = score;
    req_ch.new_payload = payload;
    req_ch.valid       = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(predict_table_op(op, score, payload));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (expected_results.size() == 0);
  endtask

  function automatic logic [SCORE_BITS-1:0] rand_score();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return SCORE_BITS'($urandom_range(100));
    if (pick < 85) return SCORE_BITS'($urandom_range(3) * 25);
    return SCORE_BITS'($urandom_range(127, 101));
  endfunction

  function automatic op_t rand_op(bit filling);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) return OP_CLEAR;
    if (filling) begin
      if (pick < 62) return OP_INSERT;
      if (pick < 77) return OP_REMOVE;
      return OP_READ;
    end
    if (pick < 22) return OP_INSERT;
    if (pick < 72) return OP_REMOVE;
    return OP_READ;
  endfunction

  task automatic test_empty_table();
    send_op(OP_REMOVE, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_CLEAR, '0, '0);
    send_op(OP_INSERT, 7'd0, 32'h0000_0000);
    send_op(OP_REMOVE, '0, '0);
  endtask

  task automatic test_fill_to_full();
    logic [SCORE_BITS-1:0] scores [DEPTH] = '{7'd100, 7'd50, 7'd50, 7'd127, 7'd0, 7'd101,
                                              7'd75, 7'd25, 7'd50, 7'd99, 7'd1, 7'd126,
                                              7'd10, 7'd60, 7'd80, 7'd30};
    send_op(OP_INSERT, scores[0], 32'hFFFF_FFFF);
    send_op(OP_INSERT, scores[1], 32'h0000_0000);
    send_op(OP_INSERT, scores[2], 32'hA5A5_A5A5);
    for (int i = 3; i < DEPTH; i++) send_op(OP_INSERT, scores[i], $urandom);
    send_op(OP_INSERT, 7'd64, 32'h5A5A_5A5A);
  endtask

  task automatic test_cursor_moves();
    send_op(OP_READ, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_REMOVE, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    bit filling;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 39) filling = ~filling;
      send_op(rand_op(filling), rand_score(), $urandom);
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    idle_on = 1'b0;
    test_random_traffic(n_items);
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (!rst) rsp_ch.ready = !(idle_on && $urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("response transaction with no operation outstanding");
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.entry_score !== want.score) begin
          $error("entry_score expected %0d actual %0d", want.score, rsp_ch.entry_score);
          err_count++;
        end
        if (rsp_ch.entry_payload !== want.payload) begin
          $error("entry_payload expected %h actual %h", want.payload, rsp_ch.entry_payload);
          err_count++;
        end
        if (rsp_ch.entry_count !== want.count) begin
          $error("entry_count expected %0d actual %0d", want.count, rsp_ch.entry_count);
          err_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp_ch.status);
          err_count++;
        end
      end
    end
  end

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.func        = OP_INSERT;
    req_ch.new_score   = '0;
    req_ch.new_payload = '0;
    rsp_ch.ready       = 1'b0;
    fill_cnt    = 0;
    read_ptr    = 0;
    err_count   = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_fill_to_full();
    test_cursor_moves();
    test_random_traffic(400);
    drain_results();
    test_back_to_back(200);
    test_random_traffic(200);

    drain_results();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sit_pkg.sv
src/sit_if.sv
src/sit_store.sv
src/sit_seq.sv
src/sorted_insertion_table.sv
src/sit_checker.sv
tb/sv/tb_sorted_insertion_table.sv
